// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the gamma mapper.
// Plain text macros only; no other definitions live here.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define TRBG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TRBG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/trbg_pkg.sv =====
// Package for the two-region blended gamma mapper: widths, codes and
// the payload types of the pipeline stages. No dependencies.
package trbg_pkg;

  localparam int PixW         = 8;
  localparam int ReqW         = 2;
  localparam int CfgIdxW      = 2;
  localparam int TableDepth   = 256;
  localparam int AddrW        = $clog2(TableDepth);
  localparam int ProdW        = 2 * PixW;
  localparam int NumFrontStg  = 3;
  localparam int NumDivStg    = PixW;
  localparam int NumStages    = NumFrontStg + NumDivStg + 1;

  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth     = 2'd1;

  localparam logic [PixW-1:0] ThresholdRst = 8'd128;
  localparam logic [PixW-1:0] WidthRst     = 8'd0;
  localparam logic [PixW-1:0] PixMax       = 8'd255;

  typedef enum logic [ReqW-1:0] {
    ReqPixel  = 2'd0,
    ReqDark   = 2'd1,
    ReqBright = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    SelDark   = 2'd0,
    SelBright = 2'd1,
    SelBlend  = 2'd2
  } sel_e;

  // Table write request toward the memories.
  typedef struct packed {
    logic             dark_we;
    logic             bright_we;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  data;
  } tbl_wr_t;

  // Window position of one pixel.
  typedef struct packed {
    sel_e            sel;
    logic [PixW-1:0] dist_end;
    logic [PixW-1:0] dist_start;
    logic [PixW-1:0] den;
  } win_t;

  typedef struct packed {
    sel_e             sel;
    logic [PixW-1:0]  den;
    logic [ProdW-1:0] prod_dark;
    logic [ProdW-1:0] prod_bright;
    logic [PixW-1:0]  dark;
    logic [PixW-1:0]  bright;
  } mul_t;

  typedef struct packed {
    sel_e             sel;
    logic [PixW-1:0]  den;
    logic [ProdW-1:0] num;
    logic [PixW-1:0]  dark;
    logic [PixW-1:0]  bright;
  } sum_t;

  // One step of the restoring divider.
  typedef struct packed {
    sel_e            sel;
    logic [PixW-1:0] den;
    logic [PixW-1:0] rem;
    logic [PixW-1:0] num_lo;
    logic [PixW-1:0] quo;
    logic [PixW-1:0] dark;
    logic [PixW-1:0] bright;
  } div_t;

endpackage

// ===== rtl/core/trbg_if.sv =====
// Valid/ready channel interfaces of the gamma mapper: pixel and table
// requests in, corrected pixels out, register writes. Uses trbg_pkg.
interface trbg_in_if import trbg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ReqW-1:0] req_type;
  logic [PixW-1:0] pixel;
  logic [PixW-1:0] entry_index;
  logic [PixW-1:0] entry_value;

  modport source (output valid, req_type, pixel, entry_index, entry_value,
                  input ready);
  modport sink (input valid, req_type, pixel, entry_index, entry_value,
                output ready);
endinterface

interface trbg_out_if import trbg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] corrected_pixel;

  modport source (output valid, corrected_pixel, input ready);
  modport sink (input valid, corrected_pixel, output ready);
endinterface

interface trbg_cfg_if import trbg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [PixW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/trbg_tables.sv =====
// Dark and bright gamma tables with one write and one registered read
// port each. Uses trbg_pkg.
module trbg_tables import trbg_pkg::*; (
  input  logic             clk_i,
  input  tbl_wr_t          wr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [PixW-1:0]  dark_o,
  output logic [PixW-1:0]  bright_o
);

  logic [PixW-1:0] dark_mem   [TableDepth];
  logic [PixW-1:0] bright_mem [TableDepth];
  logic [PixW-1:0] dark_q;
  logic [PixW-1:0] bright_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.dark_we) begin
      dark_mem[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.bright_we) begin
      bright_mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read data holds while the first stage is stalled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      dark_q   <= dark_mem[rd_addr_i];
      bright_q <= bright_mem[rd_addr_i];
    end
  end

  assign dark_o   = dark_q;
  assign bright_o = bright_q;

endmodule

// ===== rtl/core/trbg_front.sv =====
// Front of the gamma pipeline: window classification, the two weight
// products and their sum. Uses trbg_pkg.
module trbg_front import trbg_pkg::*; (
  input  logic                   clk_i,
  input  logic [NumFrontStg-1:0] en_i,
  input  logic [PixW-1:0]        pixel_i,
  input  logic [PixW-1:0]        threshold_i,
  input  logic [PixW-1:0]        width_i,
  input  logic [PixW-1:0]        dark_i,
  input  logic [PixW-1:0]        bright_i,
  output div_t                   div_o
);

  logic [PixW-2:0]  half;
  logic [PixW-1:0]  win_start;
  logic [PixW:0]    end_sum;
  logic [PixW-1:0]  win_end;
  logic [ProdW-1:0] num_full;
  win_t             win_d;
  win_t             win_q;
  mul_t             mul_q;
  sum_t             sum_q;

  always_comb begin
    half      = width_i[PixW-1:1];
    win_start = (threshold_i > {1'b0, half}) ? (threshold_i - {1'b0, half}) : '0;
    end_sum   = {1'b0, threshold_i} + {2'b00, half};
    win_end   = end_sum[PixW] ? PixMax : end_sum[PixW-1:0];

    if (pixel_i <= win_start) begin
      win_d.sel = SelDark;
    end else if (pixel_i >= win_end) begin
      win_d.sel = SelBright;
    end else begin
      win_d.sel = SelBlend;
    end
    // Only meaningful for the blend case; wraps harmlessly otherwise.
    win_d.dist_end   = win_end - pixel_i;
    win_d.dist_start = pixel_i - win_start;
    win_d.den        = win_end - win_start;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mul_q.sel         <= win_q.sel;
      mul_q.den         <= win_q.den;
      mul_q.prod_dark   <= ProdW'(win_q.dist_end) * ProdW'(dark_i);
      mul_q.prod_bright <= ProdW'(win_q.dist_start) * ProdW'(bright_i);
      mul_q.dark        <= dark_i;
      mul_q.bright      <= bright_i;
    end
  end

  // In the blend case the sum is at most 255 times the divisor and fits.
  assign num_full = mul_q.prod_dark + mul_q.prod_bright;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sum_q.sel    <= mul_q.sel;
      sum_q.den    <= mul_q.den;
      sum_q.num    <= num_full;
      sum_q.dark   <= mul_q.dark;
      sum_q.bright <= mul_q.bright;
    end
  end

  // In the blend case the numerator is below 256 times the divisor, so the
  // upper byte already is a valid partial remainder.
  always_comb begin
    div_o.sel    = sum_q.sel;
    div_o.den    = sum_q.den;
    div_o.rem    = sum_q.num[ProdW-1:PixW];
    div_o.num_lo = sum_q.num[PixW-1:0];
    div_o.quo    = '0;
    div_o.dark   = sum_q.dark;
    div_o.bright = sum_q.bright;
  end

endmodule

// ===== rtl/core/trbg_div_stage.sv =====
// One registered step of the restoring divider: brings down one numerator
// bit and produces one quotient bit. Uses trbg_pkg.
module trbg_div_stage import trbg_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t stage_i,
  output div_t stage_o
);

  logic [PixW:0] trial;
  logic [PixW:0] diff;
  logic          take;
  div_t          stage_d;
  div_t          stage_q;

  always_comb begin
    trial = {stage_i.rem, stage_i.num_lo[PixW-1]};
    diff  = trial - {1'b0, stage_i.den};
    take  = (trial >= {1'b0, stage_i.den});

    stage_d        = stage_i;
    stage_d.rem    = take ? diff[PixW-1:0] : trial[PixW-1:0];
    stage_d.num_lo = {stage_i.num_lo[PixW-2:0], 1'b0};
    stage_d.quo    = {stage_i.quo[PixW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== rtl/core/two_region_blended_gamma.sv =====
// Top level of the two-region blended gamma mapper: handshakes, register
// file, pipeline valid chain and the rounding output stage.
// Uses trbg_pkg, trbg_if, trbg_tables, trbg_front and trbg_div_stage.
//
//   channel     dir  modport  payload
//   in_chan_i   in   sink     req_type, pixel, entry_index, entry_value
//   out_chan_o  out  source   corrected_pixel
//   cfg_chan_i  in   sink     index, data
//
// One request per cycle is taken while in_chan_i.ready is high; an accepted
// pixel passes through the table read, the multiply and add stages, the eight
// one-bit divider stages and the output register before it leaves. Table
// writes finish at acceptance and produce no result.
// Reset clears the valid bits and the registers to threshold 128, width 0;
// the tables are not cleared. A stall on the output fills bubbles first.
module two_region_blended_gamma import trbg_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  trbg_in_if.sink   in_chan_i,
  trbg_out_if.source out_chan_o,
  trbg_cfg_if.sink  cfg_chan_i
);

  logic [PixW-1:0]      threshold_q;
  logic [PixW-1:0]      width_q;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;
  logic                 in_acc;
  logic                 pix_acc;
  tbl_wr_t              tbl_wr;
  logic [PixW-1:0]      tbl_dark;
  logic [PixW-1:0]      tbl_bright;
  div_t                 div_s [NumDivStg+1];
  div_t                 last;
  logic                 round_up;
  logic [PixW:0]        quo_sum;
  logic [PixW-1:0]      blend_val;
  logic [PixW-1:0]      out_d;
  logic [PixW-1:0]      out_q;

  // Register writes; any index outside the list is dropped.
  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      width_q     <= WidthRst;
    end else if (cfg_chan_i.valid) begin
      if (cfg_chan_i.index == CfgThreshold) begin
        threshold_q <= cfg_chan_i.data;
      end else if (cfg_chan_i.index == CfgWidth) begin
        width_q <= cfg_chan_i.data;
      end
    end
  end

  // A stage may load when it is empty or its content moves on.
  assign en[NumStages-1] = !vld_q[NumStages-1] || out_chan_o.ready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign in_chan_i.ready = en[0];
  assign in_acc  = in_chan_i.valid && en[0];
  assign pix_acc = in_acc && (in_chan_i.req_type == ReqPixel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pix_acc;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    tbl_wr.dark_we   = in_acc && (in_chan_i.req_type == ReqDark);
    tbl_wr.bright_we = in_acc && (in_chan_i.req_type == ReqBright);
    tbl_wr.addr      = in_chan_i.entry_index;
    tbl_wr.data      = in_chan_i.entry_value;
  end

  trbg_tables u_tables (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_en_i   (en[0]),
    .rd_addr_i (in_chan_i.pixel),
    .dark_o    (tbl_dark),
    .bright_o  (tbl_bright)
  );

  trbg_front u_front (
    .clk_i       (clk_i),
    .en_i        (en[NumFrontStg-1:0]),
    .pixel_i     (in_chan_i.pixel),
    .threshold_i (threshold_q),
    .width_i     (width_q),
    .dark_i      (tbl_dark),
    .bright_i    (tbl_bright),
    .div_o       (div_s[0])
  );

  for (genvar i = 0; i < NumDivStg; i++) begin : g_div
    trbg_div_stage u_div (
      .clk_i   (clk_i),
      .en_i    (en[NumFrontStg+i]),
      .stage_i (div_s[i]),
      .stage_o (div_s[i+1])
    );
  end

  // Round to nearest, ties to even, on the final remainder.
  always_comb begin
    last     = div_s[NumDivStg];
    round_up = ({last.rem, 1'b0} > {1'b0, last.den})
            || (({last.rem, 1'b0} == {1'b0, last.den}) && last.quo[0]);
    quo_sum  = {1'b0, last.quo} + {{PixW{1'b0}}, round_up};
    blend_val = quo_sum[PixW] ? PixMax : quo_sum[PixW-1:0];

    unique case (last.sel)
      SelDark:   out_d = last.dark;
      SelBright: out_d = last.bright;
      SelBlend:  out_d = blend_val;
      default:   out_d = last.dark;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      out_q <= out_d;
    end
  end

  assign out_chan_o.valid           = vld_q[NumStages-1];
  assign out_chan_o.corrected_pixel = out_q;

endmodule

// ===== rtl/core/trbg_checker.sv =====
// Port-level checker for the gamma mapper, bound to the top level.
// Uses assert_macros.svh and trbg_pkg.
`include "assert_macros.svh"

module trbg_checker import trbg_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [PixW-1:0] out_pixel_i,
  input logic            cfg_ready_i
);

  logic out_stall;

  assign out_stall = out_valid_i && !out_ready_i;

  // Back pressure on the input only comes from a stalled, full output.
  `TRBG_ASSERT(a_in_stall, clk_i, rst_ni, !in_ready_i |-> out_stall, "input stall without cause")

  `TRBG_ASSERT_ALWAYS(a_out_idle_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result during reset")

  `TRBG_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_i, "register port not ready")

  `TRBG_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i, "result dropped while stalled")

  `TRBG_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(out_pixel_i), "result changed")

endmodule

bind two_region_blended_gamma trbg_checker u_trbg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_chan_i.ready),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .out_pixel_i (out_chan_o.corrected_pixel),
  .cfg_ready_i (cfg_chan_i.ready)
);

// ===== test/two_region_blended_gamma_tb.sv =====
// Testbench for two_region_blended_gamma: drives pixel and table requests with random
// idling on both channels and checks every result against a directed value or a predictor.
// Depends on trbg_pkg, the trbg_*_if interfaces and the two_region_blended_gamma RTL.
`timescale 1ns / 100ps

module two_region_blended_gamma_tb;
  import trbg_pkg::*;

  localparam logic [ReqW-1:0]    ReqUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;
  localparam int NumDirRows   = 33;
  localparam int NumSegments  = 10;
  localparam int SegRequests  = 106;
  localparam int SettleCycles = 16;

  typedef enum bit {RowReq, RowCfg} row_kind_e;

  // For configuration rows, idx carries the register index and val the data.
  typedef struct {
    row_kind_e       kind;
    logic [ReqW-1:0] req;
    logic [PixW-1:0] pix;
    logic [PixW-1:0] idx;
    logic [PixW-1:0] val;
    bit              known;
    logic [PixW-1:0] result;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  trbg_in_if  in_if ();
  trbg_out_if out_if ();
  trbg_cfg_if cfg_if ();

  two_region_blended_gamma uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .cfg_chan_i (cfg_if)
  );

  // Mirror of the block's state as seen through accepted requests.
  logic [PixW-1:0] dark_lut [TableDepth];
  logic [PixW-1:0] bright_lut [TableDepth];
  bit              dark_set [TableDepth];
  bit              bright_set [TableDepth];
  int              loaded_idx [$];
  logic [PixW-1:0] gamma_thr = ThresholdRst;
  logic [PixW-1:0] gamma_width = WidthRst;

  logic [PixW-1:0] corrected_q [$];
  logic [PixW-1:0] exp_px;
  int              mismatch_cnt = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  dir_row_t dir_rows [NumDirRows] = '{
    '{RowReq, ReqDark,   8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
    '{RowReq, ReqBright, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{RowReq, ReqDark,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
    '{RowReq, ReqBright, 8'd0,   8'd255, 8'd255, 1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
    '{RowReq, ReqPixel,  8'd255, 8'd0,   8'd0,   1'b1, 8'd255},
    '{RowReq, ReqDark,   8'd0,   8'd128, 8'd10,  1'b0, 8'd0},
    '{RowReq, ReqBright, 8'd0,   8'd128, 8'd11,  1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd128, 8'd0,   8'd0,   1'b1, 8'd10},
    // The unused request code must leave dark entry 0 alone.
    '{RowReq, ReqUnused, 8'd200, 8'd0,   8'd7,   1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
    '{RowCfg, ReqPixel,  8'd0,   8'(CfgWidth), 8'd4, 1'b0, 8'd0},
    '{RowReq, ReqDark,   8'd0,   8'd127, 8'd1,   1'b0, 8'd0},
    '{RowReq, ReqBright, 8'd0,   8'd127, 8'd3,   1'b0, 8'd0},
    // Window 126..130: entry 127 hits a tie with an odd quotient, 128 one with an even.
    '{RowReq, ReqPixel,  8'd127, 8'd0,   8'd0,   1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0},
    '{RowReq, ReqDark,   8'd0,   8'd129, 8'd1,   1'b0, 8'd0},
    '{RowReq, ReqBright, 8'd0,   8'd129, 8'd2,   1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd129, 8'd0,   8'd0,   1'b0, 8'd0},
    '{RowCfg, ReqPixel,  8'd0,   8'(CfgThreshold), 8'd0, 1'b0, 8'd0},
    '{RowCfg, ReqPixel,  8'd0,   8'(CfgWidth), 8'd255, 1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
    '{RowReq, ReqPixel,  8'd127, 8'd0,   8'd0,   1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd255, 8'd0,   8'd0,   1'b1, 8'd255},
    '{RowCfg, ReqPixel,  8'd0,   8'(CfgThreshold), 8'd255, 1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd128, 8'd0,   8'd0,   1'b1, 8'd10},
    '{RowReq, ReqPixel,  8'd255, 8'd0,   8'd0,   1'b1, 8'd255},
    '{RowReq, ReqPixel,  8'd129, 8'd0,   8'd0,   1'b0, 8'd0},
    // Writes to indexes outside the register file must change nothing.
    '{RowCfg, ReqPixel,  8'd0,   8'(CfgSpare2), 8'd9, 1'b0, 8'd0},
    '{RowCfg, ReqPixel,  8'd0,   8'(CfgSpare3), 8'd1, 1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd129, 8'd0,   8'd0,   1'b0, 8'd0},
    '{RowReq, ReqPixel,  8'd128, 8'd0,   8'd0,   1'b1, 8'd10},
    '{RowReq, ReqPixel,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0}
  };

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void window_bounds(output int lo, output int hi);
    int half;
    half = int'(gamma_width) >> 1;
    lo = (int'(gamma_thr) > half) ? int'(gamma_thr) - half : 0;
    hi = (int'(gamma_thr) + half > 255) ? 255 : int'(gamma_thr) + half;
  endfunction

  function automatic logic [PixW-1:0] predict_corrected(input logic [PixW-1:0] pix);
    int lo, hi, v, d, b, num, den, q, r;
    window_bounds(lo, hi);
    v = int'(pix);
    d = int'(dark_lut[pix]);
    b = int'(bright_lut[pix]);
    if (v <= lo) return PixW'(d);
    if (v >= hi) return PixW'(b);
    den = hi - lo;
    num = (hi - v) * d + (v - lo) * b;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q % 2 == 1)) q++;
    if (q > 255) q = 255;
    return PixW'(q);
  endfunction

  // Pixel values are drawn near the window half of the time, but only among
  // entries that both tables already hold.
  function automatic logic [PixW-1:0] pick_pixel();
    int lo, hi, cand;
    window_bounds(lo, hi);
    lo = (lo > 2) ? lo - 2 : 0;
    hi = (hi < 253) ? hi + 2 : 255;
    cand = $urandom_range(1, 0) ? $urandom_range(hi, lo) : $urandom_range(255, 0);
    if (!(dark_set[cand] && bright_set[cand]))
      cand = loaded_idx[$urandom_range(loaded_idx.size() - 1, 0)];
    return PixW'(cand);
  endfunction

  function automatic logic [PixW-1:0] pick_entry();
    int lo, hi;
    window_bounds(lo, hi);
    if ($urandom_range(1, 0)) return PixW'($urandom_range(hi, lo));
    return PixW'($urandom_range(255, 0));
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance
  // with valid still high, so the next call can keep the stream going.
  task automatic send_request(input logic [ReqW-1:0] req, input logic [PixW-1:0] pix,
                              input logic [PixW-1:0] idx, input logic [PixW-1:0] val,
                              input bit known, input logic [PixW-1:0] result);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= req;
    in_if.pixel       <= pix;
    in_if.entry_index <= idx;
    in_if.entry_value <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (req == ReqPixel) begin
      corrected_q = {corrected_q, (known ? result : predict_corrected(pix))};
    end else if (req == ReqDark || req == ReqBright) begin
      if (req == ReqDark) begin
        dark_lut[idx] = val;
        dark_set[idx] = 1'b1;
      end else begin
        bright_lut[idx] = val;
        bright_set[idx] = 1'b1;
      end
      if (dark_set[idx] && bright_set[idx] && !(int'(idx) inside {loaded_idx}))
        loaded_idx = {loaded_idx, int'(idx)};
    end
    @(negedge clk_i);
  endtask

  // Stops the request stream and waits until the pipeline is empty.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (corrected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PixW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == CfgThreshold) gamma_thr = data;
    else if (idx == CfgWidth) gamma_width = data;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (corrected_q.size() == 0) begin
        $error("corrected_pixel: expected none, actual %0d", out_if.corrected_pixel);
        mismatch_cnt++;
      end else begin
        exp_px = corrected_q.pop_front();
        if (out_if.corrected_pixel !== exp_px) begin
          $error("corrected_pixel: expected %0d, actual %0d", exp_px,
                 out_if.corrected_pixel);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int seg, n, pick;
    logic [PixW-1:0] thr, wid;

    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.req_type     <= ReqPixel;
    in_if.pixel        <= '0;
    in_if.entry_index  <= '0;
    in_if.entry_value  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CfgThreshold;
    cfg_if.data        <= '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 68;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        drain();
        write_reg(dir_rows[i].idx[CfgIdxW-1:0], dir_rows[i].val);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].pix, dir_rows[i].idx, dir_rows[i].val,
                     dir_rows[i].known, dir_rows[i].result);
      end
    end

    for (seg = 0; seg < NumSegments; seg++) begin
      drain();
      case (seg)
        0: begin
          thr = 8'd0;
          wid = 8'd0;
        end
        1: begin
          thr = 8'd255;
          wid = 8'd255;
        end
        3: begin
          thr = 8'd0;
          wid = 8'd255;
        end
        4: begin
          thr = 8'd255;
          wid = 8'd0;
        end
        6: begin
          thr = 8'd128;
          wid = 8'd255;
        end
        8: begin
          thr = PixW'($urandom_range(255, 0));
          wid = PixW'($urandom_range(8, 1));
        end
        default: begin
          thr = PixW'($urandom_range(255, 0));
          wid = PixW'($urandom_range(255, 0));
        end
      endcase
      write_reg(CfgThreshold, thr);
      write_reg(CfgWidth, wid);
      if (seg % 2 == 1) write_reg(CfgSpare3, PixW'($urandom_range(255, 0)));

      if (seg < 4) begin
        send_idle_pct = 28;
        recv_idle_pct = 68;
      end else if (seg < 7) begin
        send_idle_pct = 68;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      n = 0;
      while (n < SegRequests) begin
        // Hold the stream mid-segment until every pixel has come back.
        if (seg == 5 && n == 40) drain();
        pick = $urandom_range(99, 0);
        if (pick < 6) begin
          send_request(ReqUnused, PixW'($urandom_range(255, 0)),
                       PixW'($urandom_range(255, 0)), PixW'($urandom_range(255, 0)),
                       1'b0, '0);
        end else begin
          if (pick < 42) begin
            send_request((pick < 24) ? ReqDark : ReqBright, PixW'($urandom_range(255, 0)),
                         pick_entry(),
                         ($urandom_range(9, 0) == 0) ? 8'd0 :
                         ($urandom_range(9, 0) == 0) ? 8'd255 :
                         PixW'($urandom_range(255, 0)),
                         1'b0, '0);
          end else begin
            send_request(ReqPixel, pick_pixel(), PixW'($urandom_range(255, 0)),
                         PixW'($urandom_range(255, 0)), 1'b0, '0);
          end
          n++;
        end
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
